// ----- sv/cme_pkg.sv -----
// Shared types, field widths, register indexes and the symbol code table.
package cme_pkg;

   localparam int CHAR_W  = 8;
   localparam int CODE_W  = 7;
   localparam int BITS_W  = 14;
   localparam int COUNT_W = 4;
   localparam int RATIO_W = 2;
   localparam int INDEX_W = 2;

   localparam logic [INDEX_W-1:0] CSR_START_SYMBOL = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_END_SYMBOL   = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_WIDE_RATIO   = 2'd2;

   localparam logic [CHAR_W-1:0] START_SYMBOL_RESET = 8'd65;
   localparam logic [CHAR_W-1:0] END_SYMBOL_RESET   = 8'd66;
   localparam logic [RATIO_W-1:0] WIDE_RATIO_RESET  = 2'd2;

   // One symbol in flight: character plus gap and end-of-run marks.
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] ch;
      logic              gap;
      logic              last;
   } sym_type;

   // One symbol after table lookup.
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic              gap;
      logic              last;
   } code_type;

   // Element bits of an upper-cased, mapped symbol; unknown gives all narrow.
   function automatic logic [CODE_W-1:0] symbol_code(input logic [CHAR_W-1:0] ch);
      logic [CODE_W-1:0] code;
      case (ch)
         "0":     code = 7'h03;
         "1":     code = 7'h06;
         "2":     code = 7'h09;
         "3":     code = 7'h60;
         "4":     code = 7'h12;
         "5":     code = 7'h42;
         "6":     code = 7'h21;
         "7":     code = 7'h24;
         "8":     code = 7'h30;
         "9":     code = 7'h48;
         "-":     code = 7'h0c;
         "$":     code = 7'h18;
         ":":     code = 7'h45;
         "/":     code = 7'h51;
         ".":     code = 7'h54;
         "+":     code = 7'h15;
         "A":     code = 7'h1A;
         "B":     code = 7'h29;
         "C":     code = 7'h0B;
         "D":     code = 7'h0E;
         "T":     code = 7'h1A;
         "N":     code = 7'h29;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

// ----- sv/codabar_module_encoder_core.sv -----
// Top level of the Codabar module encoder: registers, pipeline and checks.
//
// A transaction is taken at a rising edge where start is high and busy is low. It
// yields one to three symbol results (start symbol, character, end symbol), one
// per cycle, and a new transaction can be taken on the cycle its final symbol
// leaves the sequencer; busy stays high while more than one of its symbols is left.
// The first result of a transaction passes the sequencer output register, the
// lookup's normalize and code registers and the render's span and pattern
// registers before it shows on the rsp_ ports, and results follow in order at
// one per cycle. Each result is valid for exactly the one cycle
// that rsp_strobe is high; there is no backpressure, so the receiver must take
// every strobe. rsp_last_of_run marks the final result of each transaction.
// Configuration writes land on the next edge and must happen only while idle.
module codabar_module_encoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cme_pkg::CHAR_W-1:0]     req_char_code,
   input  logic                           req_is_first,
   input  logic                           req_is_last,
   input  logic                           req_no_content,
   output logic                           rsp_strobe,
   output logic [cme_pkg::BITS_W-1:0]     rsp_module_bits,
   output logic [cme_pkg::COUNT_W-1:0]    rsp_module_count,
   output logic                           rsp_last_of_run,
   input  logic                           csr_write_enable,
   input  logic [cme_pkg::INDEX_W-1:0]    csr_index,
   input  logic [cme_pkg::CHAR_W-1:0]     csr_write_data
);

   logic [cme_pkg::CHAR_W-1:0]   start_symbol_ff, start_symbol_in;
   logic [cme_pkg::CHAR_W-1:0]   end_symbol_ff, end_symbol_in;
   logic [cme_pkg::RATIO_W-1:0]  wide_ratio_ff, wide_ratio_in;

   cme_pkg::sym_type   sym;
   cme_pkg::code_type  code;

   // Register file decode; writes to unused indexes drop.
   always_comb begin
      start_symbol_in = start_symbol_ff;
      end_symbol_in   = end_symbol_ff;
      wide_ratio_in   = wide_ratio_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cme_pkg::CSR_START_SYMBOL: start_symbol_in = csr_write_data;
            cme_pkg::CSR_END_SYMBOL:   end_symbol_in   = csr_write_data;
            cme_pkg::CSR_WIDE_RATIO:
               wide_ratio_in = csr_write_data[cme_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_symbol_ff <= cme_pkg::START_SYMBOL_RESET;
         end_symbol_ff   <= cme_pkg::END_SYMBOL_RESET;
         wide_ratio_ff   <= cme_pkg::WIDE_RATIO_RESET;
      end else begin
         start_symbol_ff <= start_symbol_in;
         end_symbol_ff   <= end_symbol_in;
         wide_ratio_ff   <= wide_ratio_in;
      end
   end

   // Expand each transaction into its symbols, one per cycle.
   cme_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .char_code    (req_char_code),
      .is_first     (req_is_first),
      .is_last      (req_is_last),
      .no_content   (req_no_content),
      .start_symbol (start_symbol_ff),
      .end_symbol   (end_symbol_ff),
      .sym          (sym)
   );

   // Normalize the character and look up its seven element bits.
   cme_lookup u_lookup (
      .clock (clock),
      .reset (reset),
      .sym   (sym),
      .code  (code)
   );

   // Turn elements into bar and space modules, gap included.
   cme_render u_render (
      .clock        (clock),
      .reset        (reset),
      .wide_ratio   (wide_ratio_ff),
      .code         (code),
      .strobe       (rsp_strobe),
      .module_bits  (rsp_module_bits),
      .module_count (rsp_module_count),
      .last_of_run  (rsp_last_of_run)
   );

   // Every accepted transaction produces its first result at fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##6 rsp_strobe)
      else $error("accepted transaction produced no result at expected latency");

   // A symbol always spans seven to fourteen modules.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_module_count >= 4'd7) && (rsp_module_count <= 4'd14))
      else $error("module count out of range");

   // An empty message has two symbols, so the sequencer must hold off new input.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_no_content |=> busy)
      else $error("busy not raised for empty message");

endmodule

// ----- sv/cme_seq.sv -----
// Symbol sequencer: expands one transaction into start, character and end symbols.
module cme_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [cme_pkg::CHAR_W-1:0]  char_code,
   input  logic                        is_first,
   input  logic                        is_last,
   input  logic                        no_content,
   input  logic [cme_pkg::CHAR_W-1:0]  start_symbol,
   input  logic [cme_pkg::CHAR_W-1:0]  end_symbol,
   output cme_pkg::sym_type            sym
);

   localparam int NEED_START = 0;
   localparam int NEED_CHAR  = 1;
   localparam int NEED_END   = 2;

   logic [2:0]                   need_ff, need_in;
   logic [cme_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                         last_ff, last_in;
   cme_pkg::sym_type             sym_ff, sym_in;
   logic                         accept;

   // More than one symbol left means the item is not on its final cycle.
   assign busy = (need_ff[NEED_START] & need_ff[NEED_CHAR]) |
                 (need_ff[NEED_START] & need_ff[NEED_END]) |
                 (need_ff[NEED_CHAR] & need_ff[NEED_END]);
   assign accept = start && !busy;

   always_comb begin
      logic [2:0] remain;
      remain = need_ff;
      sym_in = '0;
      if (need_ff[NEED_START]) begin
         sym_in.valid = 1'b1;
         sym_in.ch    = start_symbol;
         sym_in.gap   = 1'b1;
         sym_in.last  = 1'b0;
         remain[NEED_START] = 1'b0;
      end else if (need_ff[NEED_CHAR]) begin
         sym_in.valid = 1'b1;
         sym_in.ch    = char_ff;
         sym_in.gap   = 1'b1;
         sym_in.last  = !last_ff;
         remain[NEED_CHAR] = 1'b0;
      end else if (need_ff[NEED_END]) begin
         sym_in.valid = 1'b1;
         sym_in.ch    = end_symbol;
         sym_in.gap   = 1'b0;
         sym_in.last  = 1'b1;
         remain[NEED_END] = 1'b0;
      end
      if (accept) begin
         need_in[NEED_START] = no_content | is_first;
         need_in[NEED_CHAR]  = !no_content;
         need_in[NEED_END]   = no_content | is_last;
         char_in = char_code;
         last_in = is_last;
      end else begin
         need_in = remain;
         char_in = char_ff;
         last_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff      <= '0;
         sym_ff.valid <= 1'b0;
      end else begin
         need_ff      <= need_in;
         sym_ff.valid <= sym_in.valid;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      sym_ff.ch   <= sym_in.ch;
      sym_ff.gap  <= sym_in.gap;
      sym_ff.last <= sym_in.last;
   end

   assign sym = sym_ff;

endmodule

// ----- sv/cme_lookup.sv -----
// Two stages: upper-case and alias mapping, then the element code table.
module cme_lookup (
   input  logic               clock,
   input  logic               reset,
   input  cme_pkg::sym_type   sym,
   output cme_pkg::code_type  code
);

   cme_pkg::sym_type  norm_ff, norm_in;
   cme_pkg::code_type code_ff, code_in;

   always_comb begin
      logic [cme_pkg::CHAR_W-1:0] ch;
      ch = sym.ch;
      if (ch >= "a" && ch <= "z") begin
         ch = ch - 8'd32;
      end
      case (ch)
         "T":     ch = "A";
         "N":     ch = "B";
         "*":     ch = "C";
         "E":     ch = "D";
         default: ch = ch;
      endcase
      norm_in    = sym;
      norm_in.ch = ch;
   end

   always_comb begin
      code_in.valid = norm_ff.valid;
      code_in.code  = cme_pkg::symbol_code(norm_ff.ch);
      code_in.gap   = norm_ff.gap;
      code_in.last  = norm_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff.valid <= 1'b0;
         code_ff.valid <= 1'b0;
      end else begin
         norm_ff.valid <= norm_in.valid;
         code_ff.valid <= code_in.valid;
      end
      norm_ff.ch   <= norm_in.ch;
      norm_ff.gap  <= norm_in.gap;
      norm_ff.last <= norm_in.last;
      code_ff.code <= code_in.code;
      code_ff.gap  <= code_in.gap;
      code_ff.last <= code_in.last;
   end

   assign code = code_ff;

endmodule

// ----- sv/cme_render.sv -----
// Two stages: element spans and offsets, then the module pattern.
module cme_render (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cme_pkg::RATIO_W-1:0]   wide_ratio,
   input  cme_pkg::code_type             code,
   output logic                          strobe,
   output logic [cme_pkg::BITS_W-1:0]    module_bits,
   output logic [cme_pkg::COUNT_W-1:0]   module_count,
   output logic                          last_of_run
);

   localparam int ELEMS = cme_pkg::CODE_W;

   logic [cme_pkg::RATIO_W-1:0]  span_ff [ELEMS];
   logic [cme_pkg::RATIO_W-1:0]  span_in [ELEMS];
   logic [cme_pkg::COUNT_W-1:0]  off_ff  [ELEMS];
   logic [cme_pkg::COUNT_W-1:0]  off_in  [ELEMS];
   logic [cme_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                         valid_ff, last_ff;

   logic                         strobe_ff;
   logic [cme_pkg::BITS_W-1:0]   bits_ff, bits_in;
   logic [cme_pkg::COUNT_W-1:0]  count_ff;
   logic                         run_last_ff;

   // Ratio codes below two behave as two.
   always_comb begin
      logic [cme_pkg::RATIO_W-1:0] ratio;
      logic [cme_pkg::COUNT_W-1:0] acc;
      ratio = wide_ratio[1] ? wide_ratio : 2'd2;
      acc   = '0;
      for (int e = 0; e < ELEMS; e++) begin
         span_in[e] = code.code[ELEMS-1-e] ? ratio : 2'd1;
         off_in[e]  = acc;
         acc        = acc + cme_pkg::COUNT_W'(span_in[e]);
      end
      cnt_in = acc + cme_pkg::COUNT_W'(code.gap);
   end

   // Bars are the even elements; first module lands in the MSB.
   always_comb begin
      logic [cme_pkg::COUNT_W-1:0] pos;
      bits_in = '0;
      for (int p = 0; p < cme_pkg::BITS_W; p++) begin
         pos = cme_pkg::COUNT_W'(p);
         for (int e = 0; e < ELEMS; e += 2) begin
            if (pos >= off_ff[e] &&
                pos < off_ff[e] + cme_pkg::COUNT_W'(span_ff[e])) begin
               bits_in[cme_pkg::BITS_W-1-p] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= code.valid;
         strobe_ff <= valid_ff;
      end
      span_ff     <= span_in;
      off_ff      <= off_in;
      cnt_ff      <= cnt_in;
      last_ff     <= code.last;
      bits_ff     <= bits_in;
      count_ff    <= cnt_ff;
      run_last_ff <= last_ff;
   end

   assign strobe       = strobe_ff;
   assign module_bits  = bits_ff;
   assign module_count = count_ff;
   assign last_of_run  = run_last_ff;

endmodule
